[sv/quantized_tanh_int8_macros.svh]
// Assertion macros for the quantized tanh block.
// Used by quantized_tanh_int8.sv; expects clk and arst_n in scope.
`ifndef QUANTIZED_TANH_INT8_MACROS_SVH
`define QUANTIZED_TANH_INT8_MACROS_SVH

// Check a property on every clock, quiet while reset is asserted.
`define QT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds on every clock out of reset.
`define QT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

[sv/qtanh_pkg.sv]
`timescale 1ns / 1ps
// Package for the quantized tanh block: payload types, register indexes,
// reset values and the exp factor table. No dependencies.
package qtanh_pkg;

	typedef struct packed {
		logic signed [7:0] sample;
		logic              end_of_tensor;
	} qtanh_in_t;

	typedef struct packed {
		logic signed [7:0] activation;
		logic              end_of_tensor_out;
	} qtanh_out_t;

	typedef enum logic [1:0] {
		REG_INPUT_SCALE = 2'd0,
		REG_INV_OUT_SCALE = 2'd1,
		REG_ACT_FLOOR = 2'd2,
		REG_ACT_CEIL = 2'd3
	} qtanh_reg_t;

	localparam int EXP_STEPS = 25;
	localparam int T_W = 25;

	localparam logic [63:0] Q62_ONE = 64'd1 << 62;
	localparam logic [63:0] EXP_BASE = Q62_ONE - (64'd1 << 50) + (64'd1 << 37)
		- 64'd11184128;

	localparam logic [15:0] INPUT_SCALE_RST = 16'd128;
	localparam logic [15:0] INV_OUT_SCALE_RST = 16'd32768;
	localparam logic [7:0] ACT_FLOOR_RST = 8'h80;
	localparam logic [7:0] ACT_CEIL_RST = 8'h7f;

	// Q62 x Q62 -> Q62, round half up
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		p = p + (128'd1 << 61);
		return p[125:62];
	endfunction

	// exp(-2^k / 4096) in Q62: base factor squared k times
	function automatic logic [63:0] exp_factor(input int k);
		logic [63:0] f;
		f = EXP_BASE;
		for (int i = 0; i < k; i++) begin
			f = mul_q62(f, f);
		end
		return f;
	endfunction

endpackage

[sv/quantized_tanh_int8.sv]
`timescale 1ns / 1ps
// Quantized int8 tanh activation, fully pipelined.
// Depends on qtanh_pkg and quantized_tanh_int8_macros.svh.
//
//  channel  | ports                        | transfer
//  ---------+------------------------------+----------------------------------
//  input    | start, busy, din             | edge with start high, busy low
//  result   | done, dout                   | edge ending the cycle done is high
//  config   | cfg_we, cfg_idx, cfg_wdata   | edge with cfg_we high
//
// One item enters every cycle; busy is always low. A result is registered
// through one stage for the argument multiply, two per exp factor over 25
// factors, one for the divider setup, one per quotient bit, one for the
// output scale multiply and one for rounding and clamping. Reset clears the
// valid bits and restores the register defaults; the receiver cannot stall,
// so nothing ever holds.
`include "quantized_tanh_int8_macros.svh"

module quantized_tanh_int8 #(
	parameter int TANH_FRAC_BITS = 15
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  qtanh_pkg::qtanh_in_t    din,
	output logic                    done,
	output qtanh_pkg::qtanh_out_t   dout,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_idx,
	input  logic [15:0]             cfg_wdata
);
	import qtanh_pkg::*;

	localparam int F = TANH_FRAC_BITS;
	localparam int QW = F + 1;        // quotient bits
	localparam int DW = F + 40;       // dividend bits
	localparam int LAT = QW + 54;     // sampled edges from transfer to strobe
	localparam logic [QW-1:0] TH_MAX = QW'((1 << F) - 1);

	// configuration registers
	logic [15:0]       in_scale_q;
	logic [15:0]       inv_scale_q;
	logic signed [7:0] floor_q;
	logic signed [7:0] ceil_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_scale_q <= INPUT_SCALE_RST;
			inv_scale_q <= INV_OUT_SCALE_RST;
			floor_q <= ACT_FLOOR_RST;
			ceil_q <= ACT_CEIL_RST;
		end else if (cfg_we) begin
			case (qtanh_reg_t'(cfg_idx))
				REG_INPUT_SCALE: in_scale_q <= cfg_wdata;
				REG_INV_OUT_SCALE: inv_scale_q <= cfg_wdata;
				REG_ACT_FLOOR: floor_q <= cfg_wdata[7:0];
				REG_ACT_CEIL: ceil_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// ---- stage 1: argument t = 2 * |sample| * input_scale (Q12)
	logic             v_s1, neg_s1, eot_s1;
	logic [T_W-1:0]   t_s1;
	logic [7:0]       mag;

	assign mag = din.sample[7] ? 8'(-din.sample) : 8'(din.sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		t_s1 <= T_W'({mag, 1'b0}) * T_W'(in_scale_q);
		neg_s1 <= din.sample[7];
		eot_s1 <= din.end_of_tensor;
	end

	// ---- stage 2: exp(-t) as a product of per-bit factors, two stages per factor
	logic [63:0]    acc_s2b [EXP_STEPS];
	logic [T_W-1:0] t_s2b [EXP_STEPS];
	logic           v_s2b [EXP_STEPS];
	logic           neg_s2b [EXP_STEPS];
	logic           eot_s2b [EXP_STEPS];

	for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
		localparam logic [63:0] FK = exp_factor(k);
		logic [63:0]    acc_in, fac;
		logic [T_W-1:0] t_in;
		logic           v_in, neg_in, eot_in;
		logic [63:0]    ll_s2a, lh_s2a, hl_s2a, hh_s2a;
		logic [T_W-1:0] t_s2a;
		logic           v_s2a, neg_s2a, eot_s2a;
		logic [127:0]   sum;

		if (k == 0) begin : g_first
			assign acc_in = Q62_ONE;
			assign t_in = t_s1;
			assign v_in = v_s1;
			assign neg_in = neg_s1;
			assign eot_in = eot_s1;
		end else begin : g_next
			assign acc_in = acc_s2b[k-1];
			assign t_in = t_s2b[k-1];
			assign v_in = v_s2b[k-1];
			assign neg_in = neg_s2b[k-1];
			assign eot_in = eot_s2b[k-1];
		end

		// multiplying by one in Q62 leaves the accumulator exact
		assign fac = t_in[k] ? FK : Q62_ONE;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s2a <= 1'b0;
				v_s2b[k] <= 1'b0;
			end else begin
				v_s2a <= v_in;
				v_s2b[k] <= v_s2a;
			end
		end

		always_ff @(posedge clk) begin
			ll_s2a <= acc_in[31:0] * fac[31:0];
			lh_s2a <= acc_in[31:0] * fac[63:32];
			hl_s2a <= acc_in[63:32] * fac[31:0];
			hh_s2a <= acc_in[63:32] * fac[63:32];
			t_s2a <= t_in;
			neg_s2a <= neg_in;
			eot_s2a <= eot_in;
		end

		assign sum = {64'd0, ll_s2a} + {32'd0, lh_s2a, 32'd0} + {32'd0, hl_s2a, 32'd0}
			+ {hh_s2a, 64'd0} + (128'd1 << 61);

		always_ff @(posedge clk) begin
			acc_s2b[k] <= sum[125:62];
			t_s2b[k] <= t_s2a;
			neg_s2b[k] <= neg_s2a;
			eot_s2b[k] <= eot_s2a;
		end
	end

	// ---- stage 3: reduce exp to Q38, form num/den and the rounded dividend
	logic [40:0]   e38_raw;
	logic [38:0]   e38, num;
	logic [39:0]   den;
	logic [DW-1:0] dvd;

	assign e38_raw = 41'((acc_s2b[EXP_STEPS-1] + (64'd1 << 23)) >> 24);
	assign e38 = (e38_raw > (41'd1 << 38)) ? (39'd1 << 38) : e38_raw[38:0];
	assign num = (39'd1 << 38) - e38;
	assign den = (40'd1 << 38) + {1'b0, e38};
	assign dvd = (DW'(num) << F) + DW'(den >> 1);

	// divider pipeline, index 0 is the setup stage
	logic [39:0]   rem_s4 [QW+1];
	logic [QW-1:0] low_s4 [QW+1];
	logic [QW-1:0] quo_s4 [QW+1];
	logic [39:0]   den_s4 [QW+1];
	logic          v_s4 [QW+1];
	logic          neg_s4 [QW+1];
	logic          eot_s4 [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4[0] <= 1'b0;
		else v_s4[0] <= v_s2b[EXP_STEPS-1];
	end

	always_ff @(posedge clk) begin
		rem_s4[0] <= 40'(dvd[DW-1:QW]);
		low_s4[0] <= dvd[QW-1:0];
		quo_s4[0] <= '0;
		den_s4[0] <= den;
		neg_s4[0] <= neg_s2b[EXP_STEPS-1];
		eot_s4[0] <= eot_s2b[EXP_STEPS-1];
	end

	// ---- stage 4: one restoring quotient bit per stage
	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [39:0] r2;
		logic        ge;

		assign r2 = {rem_s4[j][38:0], low_s4[j][QW-1]};
		assign ge = (r2 >= den_s4[j]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s4[j+1] <= 1'b0;
			else v_s4[j+1] <= v_s4[j];
		end

		always_ff @(posedge clk) begin
			rem_s4[j+1] <= ge ? (r2 - den_s4[j]) : r2;
			low_s4[j+1] <= low_s4[j] << 1;
			quo_s4[j+1] <= {quo_s4[j][QW-2:0], ge};
			den_s4[j+1] <= den_s4[j];
			neg_s4[j+1] <= neg_s4[j];
			eot_s4[j+1] <= eot_s4[j];
		end
	end

	// ---- stage 5: saturate tanh to just below one, apply output scale
	logic [F-1:0]    th;
	logic [F+15:0]   m_s5;
	logic            v_s5, neg_s5, eot_s5;

	assign th = (quo_s4[QW] > TH_MAX) ? TH_MAX[F-1:0] : quo_s4[QW][F-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4[QW];
	end

	always_ff @(posedge clk) begin
		m_s5 <= th * inv_scale_q;
		neg_s5 <= neg_s4[QW];
		eot_s5 <= eot_s4[QW];
	end

	// ---- stage 6: round half away from zero, restore sign, floor then ceiling
	logic [F+16:0]     rsum;
	logic signed [9:0] qs, qf, qc, lo10, hi10;
	qtanh_out_t        dout_q;
	logic              done_q;

	assign rsum = {1'b0, m_s5} + ((F+17)'(1) << (F + 7));
	assign qs = neg_s5 ? -$signed({1'b0, rsum[F+16:F+8]}) : $signed({1'b0, rsum[F+16:F+8]});
	assign lo10 = 10'(floor_q);
	assign hi10 = 10'(ceil_q);
	assign qf = (qs < lo10) ? lo10 : qs;
	assign qc = (qf > hi10) ? hi10 : qf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= v_s5;
	end

	always_ff @(posedge clk) begin
		dout_q.activation <= qc[7:0];
		dout_q.end_of_tensor_out <= eot_s5;
	end

	assign done = done_q;
	assign dout = dout_q;

	// ---- checks
	`QT_ASSERT(a_latency, start && !busy |-> ##LAT done, "result strobe missing after transfer")
	`QT_ASSERT(a_no_orphan, done |-> $past(v_s5), "result strobe without an item")
	`QT_ASSERT(a_ceil, done |-> dout.activation <= ceil_q, "result above ceiling")
	`QT_ASSERT(a_floor, done && floor_q <= ceil_q |-> dout.activation >= floor_q,
		"result below floor")
	`QT_ALWAYS(a_quot, !v_s4[QW] || quo_s4[QW] <= (TH_MAX + QW'(1)), "tanh quotient beyond one")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for quantized_tanh_int8: drives int8 samples, predicts each
// activation in fixed point and compares every output transfer in order.
// Depends on qtanh_pkg and the quantized_tanh_int8 RTL.
module tb_top;
	import qtanh_pkg::*;

	localparam int FRAC = 15;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 90;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	qtanh_in_t   din;
	logic        done;
	qtanh_out_t  dout;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [15:0] cfg_wdata;

	quantized_tanh_int8 #(.TANH_FRAC_BITS(FRAC)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .din(din),
		.done(done), .dout(dout), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the configuration registers
	logic [15:0]       scale_in_q412;
	logic [15:0]       inv_scale_q88;
	logic signed [7:0] act_floor;
	logic signed [7:0] act_ceil;

	qtanh_out_t pending_acts[$];
	int         mismatches;
	int         idle_cycles;
	logic       accepted_now;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Q62 x Q62 -> Q62, rounded half up
	function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) + (128'd1 << 61);
		return p[125:62];
	endfunction

	// Expected activation for one sample under the current shadow registers
	function automatic logic signed [7:0] tanh_activation(input logic signed [7:0] s);
		logic [7:0]  mag;
		logic [24:0] arg;
		logic [63:0] acc, fac, e38, num, den, th;
		logic [31:0] scaled;
		logic [31:0] qm;
		int          q;
		mag = s[7] ? 8'(-s) : 8'(s);
		arg = 25'(2 * mag * scale_in_q412);
		acc = 64'd1 << 62;
		fac = (64'd1 << 62) - (64'd1 << 50) + (64'd1 << 37) - 64'd11184128;
		// exp(-arg) from the binary expansion of arg, squaring the factor each bit
		for (int k = 0; k < 25; k++) begin
			if (arg[k])
				acc = q62_product(acc, fac);
			fac = q62_product(fac, fac);
		end
		e38 = (acc + (64'd1 << 23)) >> 24;
		if (e38 > (64'd1 << 38))
			e38 = 64'd1 << 38;
		num = (64'd1 << 38) - e38;
		den = (64'd1 << 38) + e38;
		th = ((num << FRAC) + den / 2) / den;
		// saturate tanh of one to the largest Q0.F value
		if (th > ((64'd1 << FRAC) - 1))
			th = (64'd1 << FRAC) - 1;
		scaled = 32'(th) * {16'd0, inv_scale_q88};
		qm = 32'((64'(scaled) + (64'd1 << (FRAC + 7))) >> (FRAC + 8));
		if (qm > 32'd65535)
			qm = 32'd65535;
		q = s[7] ? -int'(qm) : int'(qm);
		// floor first, then ceiling: an inverted pair yields the ceiling
		if (q < int'(act_floor))
			q = act_floor;
		if (q > int'(act_ceil))
			q = act_ceil;
		return 8'(q);
	endfunction

	// Write one register; only done while nothing is in flight
	task automatic write_reg(input qtanh_reg_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_INPUT_SCALE:   scale_in_q412 = data;
			REG_INV_OUT_SCALE: inv_scale_q88 = data;
			REG_ACT_FLOOR:     act_floor = data[7:0];
			REG_ACT_CEIL:      act_ceil = data[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one sample and hold it until the transfer; leave start high
	task automatic send_sample(input logic signed [7:0] s, input logic eot);
		qtanh_out_t exp_act;
		@(negedge clk);
		start <= 1'b1;
		din.sample <= s;
		din.end_of_tensor <= eot;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		exp_act.activation = tanh_activation(s);
		exp_act.end_of_tensor_out = eot;
		pending_acts.push_back(exp_act);
	endtask

	// Drop start for a random gap: mostly none, some short, a few long
	task automatic random_gap();
		int pick, len;
		pick = $urandom_range(99);
		len = (pick < 60) ? 0 : (pick < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
		if (len > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (len - 1) @(negedge clk);
		end
	endtask

	// Hold off the sender until every expected activation has arrived
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_acts.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_reset_defaults();
		send_sample(8'sd0, 1'b0);
		send_sample(8'sd1, 1'b1);
		send_sample(-8'sd1, 1'b0);
		send_sample(8'sd127, 1'b1);
		send_sample(-8'sd128, 1'b0);
		drain();
	endtask

	task automatic test_directed_corners();
		// saturate tanh to one with full scales
		write_reg(REG_INPUT_SCALE, 16'hffff);
		write_reg(REG_INV_OUT_SCALE, 16'hffff);
		send_sample(8'sd127, 1'b1);
		send_sample(-8'sd128, 1'b0);
		send_sample(8'sd1, 1'b0);
		drain();
		// zero input scale gives zero tanh
		write_reg(REG_INPUT_SCALE, 16'h0000);
		send_sample(8'sd127, 1'b0);
		send_sample(-8'sd128, 1'b1);
		drain();
		// zero inverse scale gives zero before the clamp
		write_reg(REG_INPUT_SCALE, 16'h1000);
		write_reg(REG_INV_OUT_SCALE, 16'h0000);
		send_sample(8'sd50, 1'b0);
		send_sample(-8'sd50, 1'b1);
		drain();
		// narrow clamp window; upper data bits must be discarded
		write_reg(REG_INV_OUT_SCALE, 16'h7fff);
		write_reg(REG_ACT_FLOOR, 16'habf6);
		write_reg(REG_ACT_CEIL, 16'h550a);
		send_sample(8'sd127, 1'b0);
		send_sample(-8'sd127, 1'b0);
		send_sample(8'sd0, 1'b1);
		drain();
		// floor above ceiling: everything collapses to the ceiling
		write_reg(REG_ACT_FLOOR, 16'h0014);
		write_reg(REG_ACT_CEIL, 16'h00ec);
		send_sample(8'sd100, 1'b0);
		send_sample(-8'sd100, 1'b1);
		send_sample(8'sd0, 1'b0);
		drain();
	endtask

	task automatic test_random_stream();
		logic [15:0] fl, ce;
		for (int phase = 0; phase < 11; phase++) begin
			// extremes on the first phases, random settings afterwards
			case (phase)
				0: begin fl = 16'h0080; ce = 16'h007f; end
				1: begin fl = 16'hff80; ce = 16'hff80; end
				default: begin fl = 16'($urandom); ce = 16'($urandom); end
			endcase
			if (phase > 3 && $urandom_range(2) != 0) begin
				fl = 16'h0080;
				ce = 16'h007f;
			end
			write_reg(REG_INPUT_SCALE, (phase == 0) ? 16'hffff :
				(phase == 1) ? 16'h0001 : 16'($urandom));
			write_reg(REG_INV_OUT_SCALE, (phase == 0) ? 16'h0001 :
				(phase == 1) ? 16'hffff : 16'($urandom));
			write_reg(REG_ACT_FLOOR, fl);
			write_reg(REG_ACT_CEIL, ce);
			for (int n = 0; n < 50; n++) begin
				send_sample(8'($urandom), 1'($urandom));
				// leave some stretches back to back
				if (phase % 3 != 2)
					random_gap();
			end
			drain();
		end
	endtask

	// Compare each output transfer against the oldest expectation
	always @(posedge clk) begin
		qtanh_out_t want;
		if (arst_n && done) begin
			if (pending_acts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected activation %0d eot %0b", dout.activation,
						dout.end_of_tensor_out);
			end else begin
				want = pending_acts.pop_front();
				if (dout.activation !== want.activation ||
						dout.end_of_tensor_out !== want.end_of_tensor_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("activation mismatch: expected %0d eot %0b, got %0d eot %0b",
							want.activation, want.end_of_tensor_out,
							dout.activation, dout.end_of_tensor_out);
				end
			end
		end
	end

	// Watchdog: count cycles with no transfer on either side
	always @(posedge clk) begin
		accepted_now = (start && !busy) || done;
		if (!arst_n || accepted_now)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		din = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		scale_in_q412 = INPUT_SCALE_RST;
		inv_scale_q88 = INV_OUT_SCALE_RST;
		act_floor = ACT_FLOOR_RST;
		act_ceil = ACT_CEIL_RST;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_directed_corners();
		test_random_stream();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_acts.size() == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
